// ===== rtl/sag_pkg.sv =====
`timescale 1ns / 1ps

package sag_pkg;

	// Default table geometry
	localparam int SLOTS_DEF     = 64;
	localparam int FLAG_BITS_DEF = 16;

	// Fixed port widths
	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 8;
	localparam int COMP_W   = 4;
	localparam int ID_W     = 32;
	localparam int STATUS_W = 2;
	localparam int FLAGS_W  = 16;
	localparam int STAT_W   = 7;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ACTIVATE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CHECK    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SET      = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_TOGGLE   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAME = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

// ===== rtl/sag_ram.sv =====
`timescale 1ns / 1ps

module sag_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/slot_allocator_with_generation_ids_top.sv =====
`timescale 1ns / 1ps

// Generational handle slot allocator. A command is taken while start is high and busy is
// low; busy then stays high for one cycle while the slot's id and flag word are
// read from the table memory, modified and written back. The result appears on the result
// ports for exactly one cycle with done high, in the cycle after busy, and the receiver
// cannot stall it: capture it when done is high. No new command is taken while busy is
// high, since the id/flag memory has a registered read that is followed by its write
// back. Active bits sit in flip-flops, so first_free and last_active come from priority
// encoders over them in the same cycle as the update. No clearing pass is needed after reset.
module slot_allocator_with_generation_ids_top #(
	parameter int SLOTS     = sag_pkg::SLOTS_DEF,
	parameter int FLAG_BITS = sag_pkg::FLAG_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic [sag_pkg::ACTION_W-1:0]             action,
	input  logic signed [sag_pkg::SLOT_W-1:0]        slot,
	input  logic [sag_pkg::COMP_W-1:0]               component,
	input  logic                                     value,
	input  logic [sag_pkg::ID_W-1:0]                 handle_id,
	output logic                                     done,
	output logic [sag_pkg::STATUS_W-1:0]             status,
	output logic                                     valid_res,
	output logic [sag_pkg::ID_W-1:0]                 slot_id,
	output logic [sag_pkg::FLAGS_W-1:0]              flags,
	output logic [sag_pkg::STAT_W-1:0]               first_free,
	output logic signed [sag_pkg::STAT_W-1:0]        last_active,
	output logic [sag_pkg::STAT_W-1:0]               active_count
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ENT_W = sag_pkg::ID_W + FLAG_BITS;

	// Command register and control state
	logic                          accept;
	logic                          busy_q;
	logic                          done_q;
	logic [sag_pkg::ACTION_W-1:0]  action_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          in_range_s1;
	logic [sag_pkg::COMP_W-1:0]    comp_s1;
	logic                          value_s1;
	logic [sag_pkg::ID_W-1:0]      hid_s1;
	logic [SLOTS-1:0]              active_q;
	logic [sag_pkg::ID_W-1:0]      next_id_q;
	logic [CNT_W-1:0]              count_q;

	// Table memory ports
	logic [IDX_W-1:0]              rd_idx;
	logic [ENT_W-1:0]              rd_data;
	logic                          wr_en;
	logic [ENT_W-1:0]              wr_data;

	// Update logic
	logic [SLOTS-1:0]              active_n;
	logic [sag_pkg::ID_W-1:0]      next_id_n;
	logic [CNT_W-1:0]              count_n;
	logic [sag_pkg::STATUS_W-1:0]  status_n;
	logic                          valid_n;
	logic [sag_pkg::ID_W-1:0]      id_n;
	logic [FLAG_BITS-1:0]          flags_n;
	logic                          cur_active;
	logic                          show;
	logic [CNT_W-1:0]              first_free_n;
	logic [IDX_W-1:0]              last_idx;
	logic                          any_active;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign rd_idx = IDX_W'(slot[sag_pkg::SLOT_W-2:0]);

	sag_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (wr_data),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	// Capture the command on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= action;
			idx_s1      <= rd_idx;
			in_range_s1 <= !slot[sag_pkg::SLOT_W-1] &&
				(32'(slot[sag_pkg::SLOT_W-2:0]) < SLOTS);
			comp_s1     <= component;
			value_s1    <= value;
			hid_s1      <= handle_id;
		end
	end

	// Read-modify-write of the addressed slot
	always_comb begin
		logic [sag_pkg::ID_W-1:0] old_id;
		logic [FLAG_BITS-1:0]     old_flags;
		logic [FLAG_BITS-1:0]     bit_mask;
		old_id     = rd_data[ENT_W-1:FLAG_BITS];
		old_flags  = rd_data[FLAG_BITS-1:0];
		bit_mask   = FLAG_BITS'(1) << comp_s1;
		cur_active = in_range_s1 && active_q[idx_s1];
		active_n   = active_q;
		next_id_n  = next_id_q;
		count_n    = count_q;
		status_n   = sag_pkg::ST_DONE;
		valid_n    = 1'b0;
		id_n       = old_id;
		flags_n    = old_flags;
		wr_en      = 1'b0;
		if (!in_range_s1 && action_s1 <= sag_pkg::ACT_TOGGLE) begin
			status_n = sag_pkg::ST_BAD;
		end else begin
			case (action_s1)
				sag_pkg::ACT_ACTIVATE: begin
					if (cur_active) begin
						status_n = sag_pkg::ST_SAME;
					end else begin
						active_n[idx_s1] = 1'b1;
						id_n             = next_id_q;
						flags_n          = '0;
						wr_en            = 1'b1;
						next_id_n        = next_id_q + 1'b1;
						count_n          = count_q + 1'b1;
					end
				end
				sag_pkg::ACT_FREE: begin
					if (!cur_active) begin
						status_n = sag_pkg::ST_SAME;
					end else begin
						active_n[idx_s1] = 1'b0;
						count_n          = count_q - 1'b1;
					end
				end
				sag_pkg::ACT_CHECK: begin
					valid_n = cur_active && (old_id == hid_s1);
				end
				sag_pkg::ACT_SET, sag_pkg::ACT_TOGGLE: begin
					if (!cur_active || 32'(comp_s1) >= FLAG_BITS) begin
						status_n = sag_pkg::ST_SAME;
					end else begin
						if (action_s1 == sag_pkg::ACT_TOGGLE) begin
							flags_n = old_flags ^ bit_mask;
						end else if (value_s1) begin
							flags_n = old_flags | bit_mask;
						end else begin
							flags_n = old_flags & ~bit_mask;
						end
						if (flags_n == old_flags) begin
							status_n = sag_pkg::ST_SAME;
						end
						wr_en = 1'b1;
					end
				end
				sag_pkg::ACT_CLEAR: begin
					active_n = '0;
					count_n  = '0;
				end
				default: begin
					status_n = sag_pkg::ST_SAME;
				end
			endcase
		end
		wr_data = {id_n, flags_n};
		wr_en   = wr_en && busy_q;
		show    = (action_s1 <= sag_pkg::ACT_TOGGLE) && in_range_s1 && active_n[idx_s1];
	end

	// Lowest inactive and highest active slot after the update
	always_comb begin
		first_free_n = CNT_W'(SLOTS);
		last_idx     = '0;
		any_active   = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_n[i]) begin
				first_free_n = CNT_W'(i);
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (active_n[i]) begin
				last_idx   = IDX_W'(i);
				any_active = 1'b1;
			end
		end
	end

	// Commit state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			active_q  <= '0;
			next_id_q <= '0;
			count_q   <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				active_q  <= active_n;
				next_id_q <= next_id_n;
				count_q   <= count_n;
			end
		end
	end

	// Hold the result for its single strobe cycle
	always_ff @(posedge clk) begin
		if (busy_q) begin
			status       <= status_n;
			valid_res    <= valid_n;
			slot_id      <= show ? id_n : '0;
			flags        <= show ? sag_pkg::FLAGS_W'(flags_n) : '0;
			first_free   <= sag_pkg::STAT_W'(first_free_n);
			last_active  <= any_active ? sag_pkg::STAT_W'(last_idx) : '1;
			active_count <= sag_pkg::STAT_W'(count_n);
		end
	end

	assign done = done_q;

endmodule
